// ===== rtl/tdpt_pkg.sv =====
package tdpt_pkg;

	// Width and ceiling of the running prime count
	localparam int unsigned COUNT_BITS = 31;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_TEST,
		ST_WRITE
	} state_t;

	// Datapath controls from the sequencer
	typedef struct packed {
		logic accept;
		logic load_div;
		logic step_div;
		logic advance;
		logic found;
		logic bound_hit;
		logic write_out;
	} ctl_t;

endpackage

// ===== rtl/trial_division_prime_test_unit.sv =====
// Trial-division primality tester. Each transferred input carries one candidate
// and gives exactly one result: the candidate, a prime flag and the count of
// primes seen since the last item that had first_of_range set (saturating at
// 2^31-1). Zero, one, two and even values above two are settled at once,
// without trials. Odd candidates try odd factors 3, 5, 7 and upward while
// factor*factor <= value, using one shared restoring remainder unit that
// retires one bit per cycle; each trial checks the bound, divides and tests
// the remainder. A prime runs every trial up to the bound; a candidate with a
// small factor stops at the first factor that divides it.
// The input stalls for the whole test; a finished result sits in an output
// register, so a new candidate can be taken while the previous result waits.
module trial_division_prime_test_unit
	import tdpt_pkg::*;
#(
	parameter int unsigned VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  first_of_range,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [VALUE_BITS-1:0] tested_value,
	output logic                  is_prime,
	output logic [COUNT_BITS-1:0] primes_so_far
);

	localparam int unsigned SQ_BITS  = VALUE_BITS + 2;
	localparam int unsigned CNT_BITS = $clog2(VALUE_BITS);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);

	state_t state_q, state_d;
	ctl_t   ctl;

	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] fac_q;
	logic [SQ_BITS-1:0]    sq_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] sh_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  prime_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  out_valid_q;

	logic                  in_xfer;
	logic                  out_free;
	logic                  needs_trial;
	logic                  over_bound;
	logic [VALUE_BITS:0]   rem_shift;
	logic                  rem_ge;
	logic [VALUE_BITS-1:0] rem_next;
	logic [COUNT_BITS-1:0] count_next;

	// Classify the incoming candidate: only odd values of three and up need trials
	assign in_xfer     = in_valid && !in_stall;
	assign needs_trial = value[0] && (value != VALUE_BITS'(1));
	assign out_free    = !out_valid_q || !out_stall;

	// Bound check: stop once factor squared exceeds the candidate
	assign over_bound = sq_q > {2'b00, val_q};

	// Restoring remainder step, one candidate bit per cycle
	assign rem_shift = {rem_q, sh_q[VALUE_BITS-1]};
	assign rem_ge    = rem_shift >= {1'b0, fac_q};
	always_comb begin
		if (rem_ge) begin
			rem_next = VALUE_BITS'(rem_shift - {1'b0, fac_q});
		end else begin
			rem_next = rem_shift[VALUE_BITS-1:0];
		end
	end

	// Saturating count update for the result being written
	always_comb begin
		if (prime_q && (count_q != COUNT_MAX)) begin
			count_next = count_q + COUNT_BITS'(1);
		end else begin
			count_next = count_q;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = needs_trial ? ST_CHECK : ST_WRITE;
				end
			end
			ST_CHECK: begin
				state_d = over_bound ? ST_WRITE : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				state_d = (rem_q == '0) ? ST_WRITE : ST_CHECK;
			end
			ST_WRITE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		ctl      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				ctl.accept = in_valid;
			end
			ST_CHECK: begin
				ctl.bound_hit = over_bound;
				ctl.load_div  = !over_bound;
			end
			ST_DIV: begin
				ctl.step_div = 1'b1;
			end
			ST_TEST: begin
				ctl.found   = (rem_q == '0);
				ctl.advance = (rem_q != '0);
			end
			ST_WRITE: begin
				ctl.write_out = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.accept && first_of_range) begin
				count_q <= '0;
			end else if (ctl.write_out) begin
				count_q <= count_next;
			end
			if (ctl.write_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Trial datapath: factor, its square, remainder and shifter
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			val_q   <= value;
			fac_q   <= VALUE_BITS'(3);
			sq_q    <= SQ_BITS'(9);
			prime_q <= (value == VALUE_BITS'(2));
		end
		if (ctl.bound_hit) begin
			prime_q <= 1'b1;
		end
		if (ctl.found) begin
			prime_q <= 1'b0;
		end
		if (ctl.load_div) begin
			rem_q <= '0;
			sh_q  <= val_q;
			cnt_q <= '0;
		end
		if (ctl.step_div) begin
			rem_q <= rem_next;
			sh_q  <= {sh_q[VALUE_BITS-2:0], 1'b0};
			cnt_q <= cnt_q + CNT_BITS'(1);
		end
		// (f+2)^2 = f^2 + 4f + 4
		if (ctl.advance) begin
			fac_q <= fac_q + VALUE_BITS'(2);
			sq_q  <= sq_q + {fac_q, 2'b00} + SQ_BITS'(4);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.write_out) begin
			tested_value  <= val_q;
			is_prime      <= prime_q;
			primes_so_far <= count_next;
		end
	end

	assign out_valid = out_valid_q;

	// A new result appears only from the write state
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.write_out |-> (state_q == ST_WRITE) && out_free)
		else $error("result written outside write state or over a held result");

	// A prime verdict is never given to an even value other than two
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_prime) |-> (tested_value[0] || tested_value == VALUE_BITS'(2)))
		else $error("even value reported prime");

	// Trial factors stay odd during division
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> fac_q[0])
		else $error("even trial factor");

	// Remainder after a full division is below the factor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST) |-> (rem_q < fac_q))
		else $error("remainder not reduced below factor");

	// The input is taken only while idle, and each transfer starts a test in the check or write state
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_CHECK || state_q == ST_WRITE))
		else $error("transfer did not start a test");

endmodule

// ===== verif/tb_trial_division_prime_test_unit.sv =====
`timescale 1ns / 100ps

module tb_trial_division_prime_test_unit;
	import tdpt_pkg::*;

	localparam int unsigned VBITS = 31;
	localparam logic [VBITS-1:0] VALUE_TOP = {VBITS{1'b1}};
	localparam int N_ROWS = 21;
	localparam int N_RANDOM = 80;
	localparam int TAIL_CYCLES = 40;

	// One expected result
	typedef struct packed {
		logic [VBITS-1:0]      tested;
		logic                  prime;
		logic [COUNT_BITS-1:0] count;
	} verdict_t;

	// One directed row: candidate, clear flag, and a hand-typed answer where obvious
	typedef struct packed {
		logic [VBITS-1:0]      value;
		logic                  first;
		logic                  typed;
		logic                  prime;
		logic [COUNT_BITS-1:0] count;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [VBITS-1:0]      value = '0;
	logic                  first_of_range = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [VBITS-1:0]      tested_value;
	logic                  is_prime;
	logic [COUNT_BITS-1:0] primes_so_far;

	verdict_t              pending_verdicts[$];
	logic [COUNT_BITS-1:0] running_prime_count = '0;
	int                    mismatches = 0;
	bit                    calm = 1'b0;

	// Directed candidates: specials, squares on the bound, extremes of the value field
	row_t directed_rows [N_ROWS] = '{
		'{31'd0,          1'b0, 1'b1, 1'b0, 31'd0},
		'{31'd1,          1'b0, 1'b1, 1'b0, 31'd0},
		'{31'd2,          1'b0, 1'b1, 1'b1, 31'd1},
		'{31'd3,          1'b1, 1'b1, 1'b1, 31'd1},
		'{31'd4,          1'b0, 1'b1, 1'b0, 31'd1},
		'{31'd5,          1'b0, 1'b0, 1'b0, 31'd0},
		'{31'd9,          1'b0, 1'b0, 1'b0, 31'd0},
		'{31'd15,         1'b0, 1'b0, 1'b0, 31'd0},
		'{31'd25,         1'b0, 1'b0, 1'b0, 31'd0},
		'{31'd49,         1'b0, 1'b0, 1'b0, 31'd0},
		'{31'd97,         1'b0, 1'b0, 1'b0, 31'd0},
		'{31'd121,        1'b0, 1'b0, 1'b0, 31'd0},
		'{31'd2147483646, 1'b1, 1'b1, 1'b0, 31'd0},
		'{31'd2147483647, 1'b0, 1'b1, 1'b1, 31'd1},
		'{31'd2147483645, 1'b0, 1'b0, 1'b0, 31'd0},
		'{31'd1073741824, 1'b0, 1'b0, 1'b0, 31'd0},
		'{31'd1431655765, 1'b0, 1'b0, 1'b0, 31'd0},
		'{31'd65521,      1'b1, 1'b0, 1'b0, 31'd0},
		'{31'd65537,      1'b0, 1'b0, 1'b0, 31'd0},
		'{31'd1,          1'b1, 1'b1, 1'b0, 31'd0},
		'{31'd3,          1'b0, 1'b1, 1'b1, 31'd1}
	};

	trial_division_prime_test_unit #(
		.VALUE_BITS(VBITS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.value         (value),
		.first_of_range(first_of_range),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.tested_value  (tested_value),
		.is_prime      (is_prime),
		.primes_so_far (primes_so_far)
	);

	always #2 clk = ~clk;

	// Exact trial division with the integer bound
	function automatic logic divides_none(logic [VBITS-1:0] v);
		longint unsigned n;
		longint unsigned f;
		n = v;
		if (n < 2)
			return 1'b0;
		if (n == 2)
			return 1'b1;
		if ((n & 1) == 0)
			return 1'b0;
		for (f = 3; f * f <= n; f += 2) begin
			if (n % f == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Advance the running count and form the verdict for one candidate
	function automatic verdict_t judge_candidate(logic [VBITS-1:0] v, logic f);
		verdict_t r;
		logic     p;
		if (f)
			running_prime_count = '0;
		p = divides_none(v);
		if (p && running_prime_count != COUNT_MAX)
			running_prime_count = running_prime_count + 1'b1;
		r.tested = v;
		r.prime  = p;
		r.count  = running_prime_count;
		return r;
	endfunction

	function automatic bit take_a_break();
		return !calm && ($urandom_range(99) < 31);
	endfunction

	// Offer one candidate, hold it until the transfer, then record the expectation
	task automatic offer_candidate(input logic [VBITS-1:0] v, input logic f,
			input bit typed, input verdict_t typed_verdict);
		verdict_t predicted;
		while (take_a_break()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		value          <= v;
		first_of_range <= f;
		do @(posedge clk); while (in_stall);
		predicted = judge_candidate(v, f);
		pending_verdicts.push_back(typed ? typed_verdict : predicted);
	endtask

	// Random candidate: mostly small, some medium, some large with a small factor
	function automatic logic [VBITS-1:0] pick_candidate();
		int unsigned    kind;
		int unsigned    p;
		int unsigned    q;
		logic [31:0]    raw;
		kind = $urandom_range(99);
		raw  = $urandom;
		if (kind < 15) begin
			return VBITS'($urandom_range(15));
		end else if (kind < 70) begin
			return VBITS'($urandom_range(4095));
		end else if (kind < 80) begin
			return VBITS'($urandom_range(262143));
		end else if (kind < 90) begin
			return raw[VBITS-1:0] & ~VBITS'(1);
		end else begin
			case ($urandom_range(4))
				0: p = 3;
				1: p = 5;
				2: p = 7;
				3: p = 11;
				default: p = 13;
			endcase
			q = $urandom_range(32'(VALUE_TOP) / p, 2);
			return VBITS'(p * q);
		end
	endfunction

	// Check each transferred result against the oldest expectation; stall at random
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result: tested_value %0d", tested_value);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				if (tested_value !== want.tested) begin
					$error("tested_value: expected %0d, got %0d", want.tested, tested_value);
					mismatches++;
				end
				if (is_prime !== want.prime) begin
					$error("is_prime: expected %0d, got %0d (value %0d)",
						want.prime, is_prime, want.tested);
					mismatches++;
				end
				if (primes_so_far !== want.count) begin
					$error("primes_so_far: expected %0d, got %0d (value %0d)",
						want.count, primes_so_far, want.tested);
					mismatches++;
				end
			end
		end
		out_stall <= take_a_break();
	end

	initial begin
		verdict_t typed_verdict;
		verdict_t unused;
		logic     f;
		unused = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int i = 0; i < N_ROWS; i++) begin
			typed_verdict.tested = directed_rows[i].value;
			typed_verdict.prime  = directed_rows[i].prime;
			typed_verdict.count  = directed_rows[i].count;
			offer_candidate(directed_rows[i].value, directed_rows[i].first,
				directed_rows[i].typed, typed_verdict);
		end

		// Random candidates, with a stretch of steady flow in the middle
		for (int i = 0; i < N_RANDOM; i++) begin
			calm = (i >= 40 && i < 60);
			f = ($urandom_range(7) == 0);
			offer_candidate(pick_candidate(), f, 1'b0, unused);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// Drain, then watch for stray results
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#(20_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tdpt_pkg.sv
rtl/trial_division_prime_test_unit.sv
verif/tb_trial_division_prime_test_unit.sv
